[hw/rtl/dsm2fe_pkg.sv]
// Shared constants and widths for the DSM2 frame edge encoder.
`timescale 1ns / 1ps

package dsm2fe_pkg;

    localparam int CHANNEL_COUNT = 6;
    localparam int BIT_TICKS     = 16;

    localparam int POS_W   = 3;
    localparam int LEN_W   = 9;
    localparam int CNT_W   = 4;
    localparam int TIME_W  = 16;
    localparam int PULSE_W = 10;
    localparam int CFG_W   = 8;

    localparam logic [TIME_W-1:0] START_TIME = 16'd100;
    localparam logic [TIME_W-1:0] CLOSE_TIME = 16'd44010;

    localparam logic [1:0] CFG_PROTOCOL_MODE = 2'd0;
    localparam logic [1:0] CFG_FLAG_BITS     = 2'd1;
    localparam logic [1:0] CFG_MODEL_ID      = 2'd2;

    localparam logic [1:0] MODE_LP45 = 2'd0;
    localparam logic [1:0] MODE_DSM2 = 2'd1;
    localparam logic [1:0] MODE_DSMX = 2'd2;

    localparam logic [7:0] HEAD_LP45 = 8'h00;
    localparam logic [7:0] HEAD_DSM2 = 8'h10;
    localparam logic [7:0] HEAD_DSMX = 8'h18;

    localparam logic [PULSE_W-1:0] PULSE_MAX    = 10'd1023;
    localparam logic [16:0]        PULSE_OFFSET = 17'd512;
    localparam logic [20:0]        SCALE_MUL    = 21'd13;

    localparam logic [1:0] BYTE_HEAD  = 2'd0;
    localparam logic [1:0] BYTE_MODEL = 2'd1;
    localparam logic [1:0] BYTE_CHAN  = 2'd2;
    localparam logic [1:0] BYTE_PULSE = 2'd3;

endpackage

[hw/rtl/dsm2_frame_edge_encoder.sv]
// Top level of the DSM2 frame edge encoder: byte sequencer and edge timer.
//
// Channel   Direction  Handshake         Payload
// s_*       in         tvalid/tready     tdata[15:0] channel_value (signed)
// m_*       out        tvalid/tready     tdata[15:0] edge_time, tlast last_of_run,
//                                        tuser frame_end
// cfg_*     in         cfg_we            cfg_index register, cfg_data value
//
// Each byte passes through the load, bit and final states of the bit sequencer and one timer adder.
// The first channel of a frame also passes through the scale and start states, the others go from scale to load.
// Every cycle in which a finished beat waits on m_tready stalls the sequencer.
// Reset clears the channel position, so the next beat starts a new frame.
`timescale 1ns / 1ps

module dsm2_frame_edge_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] channel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] edge_time
    output logic        m_tlast,
    output logic        m_tuser,   // [0] frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_BIT   = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    localparam int POS_W  = dsm2fe_pkg::POS_W;
    localparam int LEN_W  = dsm2fe_pkg::LEN_W;
    localparam int CNT_W  = dsm2fe_pkg::CNT_W;
    localparam int TIME_W = dsm2fe_pkg::TIME_W;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [7:0]        flag_reg;
    logic [7:0]        model_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  cur_pos_reg, cur_pos_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              parity_reg, parity_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [7:0]        shift_reg, shift_next;
    logic              lev_reg, lev_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  bit_reg, bit_next;
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic              out_last_reg, out_last_next;
    logic              out_end_reg, out_end_next;

    logic                               accept;
    logic                               advance;
    logic [dsm2fe_pkg::PULSE_W-1:0]     pulse;
    logic [7:0]                         head;
    logic [7:0]                         byte_sel;
    logic [LEN_W-1:0]                   edge_len;
    logic [TIME_W-1:0]                  edge_sum;
    logic [POS_W:0]                     pos_inc;

    assign accept  = s_tvalid && s_tready;
    assign advance = !out_valid_reg || m_tready;

    dsm2fe_scale u_scale
    (
        .clk    (clk),
        .load   (accept),
        .sample ($signed(s_tdata)),
        .pulse  (pulse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dsm2fe_pkg::MODE_DSMX;
            flag_reg  <= '0;
            model_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsm2fe_pkg::CFG_PROTOCOL_MODE: mode_reg  <= cfg_data[1:0];
                dsm2fe_pkg::CFG_FLAG_BITS:     flag_reg  <= cfg_data;
                dsm2fe_pkg::CFG_MODEL_ID:      model_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (mode_reg)
            dsm2fe_pkg::MODE_LP45: head = dsm2fe_pkg::HEAD_LP45;
            dsm2fe_pkg::MODE_DSM2: head = dsm2fe_pkg::HEAD_DSM2;
            default:               head = dsm2fe_pkg::HEAD_DSMX;
        endcase
    end

    always_comb
    begin
        case (byte_idx_reg)
            dsm2fe_pkg::BYTE_HEAD:  byte_sel = head | flag_reg;
            dsm2fe_pkg::BYTE_MODEL: byte_sel = model_reg;
            dsm2fe_pkg::BYTE_CHAN:  byte_sel = 8'({cur_pos_reg, pulse[9:8]});
            default:                byte_sel = pulse[7:0];
        endcase
    end

    // The stop bits lengthen the closing edge of each character by one bit.
    assign edge_len = (state_reg == ST_FINAL) ? LEN_W'(len_reg + LEN_W'(dsm2fe_pkg::BIT_TICKS))
                                              : len_reg;
    assign edge_sum = time_reg + TIME_W'(edge_len) + (parity_reg ? 16'd2 : 16'hFFFE);
    assign pos_inc  = {1'b0, cur_pos_reg} + (POS_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_pos_next   = cur_pos_reg;
        time_next      = time_reg;
        parity_next    = parity_reg;
        byte_idx_next  = byte_idx_reg;
        shift_next     = shift_reg;
        lev_next       = lev_reg;
        len_next       = len_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_time_next  = out_time_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_pos_next = (32'(pos_reg) >= dsm2fe_pkg::CHANNEL_COUNT) ? '0 : pos_reg;
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (cur_pos_reg == '0)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    byte_idx_next = dsm2fe_pkg::BYTE_CHAN;
                    state_next    = ST_LOAD;
                end
            end
            ST_START:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = dsm2fe_pkg::START_TIME;
                    out_last_next  = 1'b0;
                    out_end_next   = 1'b0;
                    time_next      = dsm2fe_pkg::START_TIME;
                    parity_next    = 1'b1;
                    byte_idx_next  = dsm2fe_pkg::BYTE_HEAD;
                    state_next     = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                shift_next = byte_sel;
                lev_next   = 1'b0;
                len_next   = LEN_W'(dsm2fe_pkg::BIT_TICKS);
                bit_next   = '0;
                state_next = ST_BIT;
            end
            ST_BIT:
            begin
                if (advance)
                begin
                    if (shift_reg[0] != lev_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_time_next  = edge_sum;
                        out_last_next  = 1'b0;
                        out_end_next   = 1'b0;
                        time_next      = edge_sum;
                        parity_next    = !parity_reg;
                        len_next       = LEN_W'(dsm2fe_pkg::BIT_TICKS);
                        lev_next       = shift_reg[0];
                    end
                    else
                    begin
                        len_next = LEN_W'(len_reg + LEN_W'(dsm2fe_pkg::BIT_TICKS));
                    end
                    shift_next = {1'b1, shift_reg[7:1]};
                    if (bit_reg == CNT_W'(8))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        bit_next = bit_reg + CNT_W'(1);
                    end
                end
            end
            ST_FINAL:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = edge_sum;
                    out_last_next  = 1'b0;
                    out_end_next   = 1'b0;
                    time_next      = edge_sum;
                    parity_next    = !parity_reg;
                    if (byte_idx_reg == dsm2fe_pkg::BYTE_PULSE)
                    begin
                        out_last_next = 1'b1;
                        if (32'(pos_inc) >= dsm2fe_pkg::CHANNEL_COUNT)
                        begin
                            out_time_next = dsm2fe_pkg::CLOSE_TIME;
                            out_end_next  = 1'b1;
                            pos_next      = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc[POS_W-1:0];
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            time_reg      <= '0;
            parity_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            time_reg      <= time_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pos_reg  <= cur_pos_next;
        byte_idx_reg <= byte_idx_next;
        shift_reg    <= shift_next;
        lev_reg      <= lev_next;
        len_reg      <= len_next;
        bit_reg      <= bit_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_time_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end beat without last_of_run");

    a_end_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == dsm2fe_pkg::CLOSE_TIME)
        else $error("frame end beat with wrong edge time");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    a_start_beat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START && advance |=> m_tvalid && m_tdata == dsm2fe_pkg::START_TIME)
        else $error("frame start beat missing");
`endif

endmodule

[hw/rtl/dsm2fe_scale.sv]
// Channel scaler: pulse = clamp(floor(x * 13 / 32) + 512, 0, 1023).
`timescale 1ns / 1ps

module dsm2fe_scale
(
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [15:0]                 sample,
    output logic        [dsm2fe_pkg::PULSE_W-1:0] pulse
);

    logic signed [20:0] prod_reg;
    logic signed [20:0] prod_next;
    logic signed [16:0] offset_sum;

    assign prod_next = 21'(sample) * $signed(dsm2fe_pkg::SCALE_MUL);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // The top sixteen bits of the product are the floored quotient by 32.
    assign offset_sum = {prod_reg[20], prod_reg[20:5]} + $signed(dsm2fe_pkg::PULSE_OFFSET);

    always_comb
    begin
        if (offset_sum < 0)
        begin
            pulse = '0;
        end
        else if (offset_sum > 17'sd1023)
        begin
            pulse = dsm2fe_pkg::PULSE_MAX;
        end
        else
        begin
            pulse = offset_sum[dsm2fe_pkg::PULSE_W-1:0];
        end
    end

endmodule
